### hw/rtl/mono_page_rect_fill_flush_defines.svh
// Assertion macros used by the checker module of the page framebuffer.
`ifndef MONO_PAGE_RECT_FILL_FLUSH_DEFINES_SVH
`define MONO_PAGE_RECT_FILL_FLUSH_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define MPRF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mprf check failed");

// Consequent in the cycle after the antecedent.
`define MPRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mprf check failed");

`endif

### hw/rtl/mprf_pkg.sv
// Types and constants of the monochrome page framebuffer.
package mprf_pkg;

    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_PULL  = 2'd2;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

    localparam int ROWS_PER_PAGE = 8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rect_x;
        logic [7:0] rect_y;
        logic [7:0] rect_w;
        logic [7:0] rect_h;
        logic       fill_color;
    } t_req_word;

    typedef struct packed {
        logic       tx_valid;
        logic       tx_is_command;
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_res_word;

endpackage

### hw/rtl/mono_page_rect_fill_flush.sv
// Top level: page framebuffer with rectangle fill, clear and dirty-span flush stream.
//
// Usage
//   Request words enter on i_req_word, taken at a clock edge where start is high
//   and busy is low. Every request word gives exactly one result word on
//   o_res_word, shown for one cycle while o_strobe is high; the receiver cannot
//   stall, so it must take the word in that cycle. o_strobe always comes in the
//   cycle where busy has dropped again, so start may be held high for back-to-back use.
// Steps (accept edge to strobe cycle), one request at a time
//   pull, column command bytes:        one pull step
//   pull, page command or data byte:   a pull step, then a begin lookup or frame read step
//   empty fill, unused request code:   strobe straight from idle
//   fill: one page step per page, plus one step per clipped column on each covered page,
//         one frame read-modify-write per column through the shared address unit
//   clear: a sweep over the whole frame, one frame byte zeroed per cycle
// Reset
//   i_rst_n is synchronous, active low. After it is released the frame store is
//   swept to zero, all PAGE_COUNT*COLUMN_COUNT bytes (1024 by default), with busy
//   high and no result word; dirty spans and the stream position reset at once.
module mono_page_rect_fill_flush #(
    parameter int PAGE_COUNT   = 8,
    parameter int COLUMN_COUNT = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mprf_pkg::t_req_word   i_req_word,
    output logic                  o_strobe,
    output mprf_pkg::t_res_word   o_res_word
);

    import mprf_pkg::*;

    localparam int DEPTH     = PAGE_COUNT * COLUMN_COUNT;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PAGE_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W     = $clog2(COLUMN_COUNT);
    localparam int LEN_W     = COL_W + 1;
    localparam int ROW_COUNT = PAGE_COUNT * ROWS_PER_PAGE;

    // Stream phases within one page.
    localparam logic [1:0] PHASE_PAGE   = 2'd0;
    localparam logic [1:0] PHASE_COL_LO = 2'd1;
    localparam logic [1:0] PHASE_COL_HI = 2'd2;
    localparam logic [1:0] PHASE_DATA   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FILL_PAGE,
        ST_FILL_COL,
        ST_PULL,
        ST_PULL_PAGE,
        ST_PULL_DATA
    } t_state;

    t_state              r_state;

    // Dirty spans, one per page; length zero means clean.
    logic [COL_W-1:0]    r_begin [PAGE_COUNT];
    logic [LEN_W-1:0]    r_len   [PAGE_COUNT];

    // Stream position. r_page also walks the pages during a fill: a fill
    // restarts the stream, so the old page number is not needed afterwards.
    logic [PAGE_W-1:0]   r_page;
    logic [1:0]          r_phase;
    logic [LEN_W-1:0]    r_flush_col;

    // Latched fill rectangle, end bounds exclusive.
    logic [COL_W-1:0]    r_x;
    logic [LEN_W-1:0]    r_xe;
    logic [7:0]          r_y;
    logic [7:0]          r_ye;
    logic                r_color;
    logic [COL_W-1:0]    r_col;
    logic [7:0]          r_mask;

    // Write-back of the read-modify-write, in the cycle after the read.
    logic                r_wb_valid;
    logic [ADDR_W-1:0]   r_wb_addr;

    // Zeroing sweep after reset and on clear.
    logic [ADDR_W-1:0]   r_sweep_addr;
    logic                r_sweep_emit;

    logic                r_strobe;
    t_res_word           r_res;

    // Request decode
    logic [COL_W-1:0]    x_clamp;
    logic [8:0]          xe_sum;
    logic [LEN_W-1:0]    xe_clip;
    logic [7:0]          y_clamp;
    logic [8:0]          ye_sum;
    logic [7:0]          ye_clip;
    logic                rect_empty;

    // Current page view
    logic [COL_W-1:0]    begin_cur;
    logic [LEN_W-1:0]    len_cur;
    logic [PAGE_COUNT-1:0] dirty;
    logic [PAGE_COUNT-1:0] page_onehot;
    logic                any_dirty;
    logic                others_dirty;
    logic [PAGE_W-1:0]   first_page;
    logic                last_page;
    logic [1:0]          eff_phase;
    logic [LEN_W-1:0]    col_use;
    logic                flush_done;

    // Fill helpers
    logic [7:0]          page_base;
    logic [7:0]          page_mask;
    logic [COL_W-1:0]    span_b_old;
    logic [LEN_W-1:0]    span_e_old;
    logic [COL_W-1:0]    span_begin;
    logic [LEN_W-1:0]    span_end;
    logic [LEN_W-1:0]    span_len;

    // Shared address unit and frame store port
    logic [COL_W-1:0]    addr_col;
    logic [ADDR_W:0]     addr_full;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [7:0]          ram_rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [7:0]          ram_wdata;
    logic [7:0]          wb_data;

    // ---------------------------------------------------------------------
    // Clamp the corner, clip the size. With the corner clamped inside the
    // frame, the clipped size is zero only when the requested size is.
    always_comb begin
        x_clamp = (i_req_word.rect_x > 8'(COLUMN_COUNT - 1)) ?
                  COL_W'(COLUMN_COUNT - 1) : i_req_word.rect_x[COL_W-1:0];
        xe_sum  = 9'(x_clamp) + 9'(i_req_word.rect_w);
        xe_clip = (xe_sum > 9'(COLUMN_COUNT)) ? LEN_W'(COLUMN_COUNT) : LEN_W'(xe_sum);
        y_clamp = (i_req_word.rect_y > 8'(ROW_COUNT - 1)) ?
                  8'(ROW_COUNT - 1) : i_req_word.rect_y;
        ye_sum  = 9'(y_clamp) + 9'(i_req_word.rect_h);
        ye_clip = (ye_sum > 9'(ROW_COUNT)) ? 8'(ROW_COUNT) : ye_sum[7:0];
        rect_empty = (i_req_word.rect_w == 8'd0) || (i_req_word.rect_h == 8'd0);
    end

    // ---------------------------------------------------------------------
    // Dirty state of the page under r_page, and the lowest dirty page.
    assign begin_cur = r_begin[r_page];
    assign len_cur   = r_len[r_page];
    assign last_page = (r_page == PAGE_W'(PAGE_COUNT - 1));

    always_comb begin
        for (int p = 0; p < PAGE_COUNT; p++) begin
            dirty[p] = (r_len[p] != '0);
        end
        first_page = '0;
        for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
            if (dirty[p]) begin
                first_page = PAGE_W'(p);
            end
        end
    end

    assign any_dirty    = |dirty;
    assign page_onehot  = PAGE_COUNT'(1) << r_page;
    assign others_dirty = |(dirty & ~page_onehot);

    // A page that went clean under the stream sends it back to the scan.
    assign eff_phase = ((r_phase != PHASE_PAGE) && (len_cur == '0)) ? PHASE_PAGE : r_phase;

    assign col_use    = (r_flush_col >= LEN_W'(COLUMN_COUNT)) ? LEN_W'(begin_cur) : r_flush_col;
    assign flush_done = ((LEN_W+1)'(r_flush_col) >=
                         (LEN_W+1)'(begin_cur) + (LEN_W+1)'(len_cur));

    // ---------------------------------------------------------------------
    // Row mask of the current page and the widened dirty span.
    assign page_base = 8'(r_page) << 3;

    always_comb begin
        for (int i = 0; i < ROWS_PER_PAGE; i++) begin
            page_mask[i] = ((page_base + 8'(i)) >= r_y) && ((page_base + 8'(i)) < r_ye);
        end
    end

    always_comb begin
        span_b_old = (len_cur == '0) ? r_x  : begin_cur;
        span_e_old = (len_cur == '0) ? r_xe : LEN_W'(begin_cur) + len_cur;
        span_begin = (r_x < span_b_old) ? r_x : span_b_old;
        span_end   = (r_xe > span_e_old) ? r_xe : span_e_old;
        span_len   = span_end - LEN_W'(span_begin);
    end

    // ---------------------------------------------------------------------
    // Shared address unit: page * COLUMN_COUNT + column, for fill and pull.
    assign addr_col  = (r_state == ST_FILL_COL) ? r_col : col_use[COL_W-1:0];
    assign addr_full = (ADDR_W+1)'(r_page) * (ADDR_W+1)'(COLUMN_COUNT) + (ADDR_W+1)'(addr_col);
    assign ram_raddr = addr_full[ADDR_W-1:0];

    assign wb_data   = r_color ? (ram_rdata | r_mask) : (ram_rdata & ~r_mask);
    assign ram_we    = (r_state == ST_SWEEP) || r_wb_valid;
    assign ram_waddr = (r_state == ST_SWEEP) ? r_sweep_addr : r_wb_addr;
    assign ram_wdata = (r_state == ST_SWEEP) ? 8'h00 : wb_data;

    mprf_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_sweep_emit <= 1'b0;
            r_page       <= '0;
            r_phase      <= PHASE_PAGE;
            r_flush_col  <= '0;
            r_wb_valid   <= 1'b0;
            r_strobe     <= 1'b0;
            for (int p = 0; p < PAGE_COUNT; p++) begin
                r_begin[p] <= '0;
                r_len[p]   <= '0;
            end
        end else begin
            r_strobe   <= 1'b0;
            r_wb_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_res <= '0;
                        case (i_req_word.req_type)
                            REQ_FILL: begin
                                r_x     <= x_clamp;
                                r_xe    <= xe_clip;
                                r_y     <= y_clamp;
                                r_ye    <= ye_clip;
                                r_color <= i_req_word.fill_color;
                                if (rect_empty) begin
                                    r_strobe <= 1'b1;
                                end else begin
                                    // A real fill aborts the page stream in progress.
                                    r_page  <= '0;
                                    r_phase <= PHASE_PAGE;
                                    r_state <= ST_FILL_PAGE;
                                end
                            end
                            REQ_CLEAR: begin
                                for (int p = 0; p < PAGE_COUNT; p++) begin
                                    r_begin[p] <= '0;
                                    r_len[p]   <= LEN_W'(COLUMN_COUNT);
                                end
                                r_phase      <= PHASE_PAGE;
                                r_sweep_addr <= '0;
                                r_sweep_emit <= 1'b1;
                                r_state      <= ST_SWEEP;
                            end
                            REQ_PULL: begin
                                r_state <= ST_PULL;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                            end
                        endcase
                    end
                end

                ST_SWEEP: begin
                    if (r_sweep_addr == ADDR_W'(DEPTH - 1)) begin
                        r_strobe     <= r_sweep_emit;
                        r_sweep_emit <= 1'b0;
                        r_state      <= ST_IDLE;
                    end else begin
                        r_sweep_addr <= r_sweep_addr + 1'b1;
                    end
                end

                ST_FILL_PAGE: begin
                    if (page_mask != 8'h00) begin
                        r_begin[r_page] <= span_begin;
                        r_len[r_page]   <= span_len;
                        r_mask          <= page_mask;
                        r_col           <= r_x;
                        r_state         <= ST_FILL_COL;
                    end else if (last_page) begin
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_page <= r_page + 1'b1;
                    end
                end

                ST_FILL_COL: begin
                    // Read this column now, write it back next cycle.
                    r_wb_valid <= 1'b1;
                    r_wb_addr  <= ram_raddr;
                    if (LEN_W'(r_col) + 1'b1 == r_xe) begin
                        if (last_page) begin
                            r_strobe <= 1'b1;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_page  <= r_page + 1'b1;
                            r_state <= ST_FILL_PAGE;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end

                ST_PULL: begin
                    case (eff_phase)
                        PHASE_PAGE: begin
                            r_phase <= PHASE_PAGE;
                            if (any_dirty) begin
                                r_page  <= first_page;
                                r_state <= ST_PULL_PAGE;
                            end else begin
                                // Nothing dirty: all-zero word.
                                r_strobe <= 1'b1;
                                r_state  <= ST_IDLE;
                            end
                        end
                        PHASE_COL_LO: begin
                            r_res <= '{tx_valid: 1'b1, tx_is_command: 1'b1,
                                       tx_byte: NIBBLE_MASK & 8'(begin_cur), tx_last: 1'b0};
                            r_phase  <= PHASE_COL_HI;
                            r_strobe <= 1'b1;
                            r_state  <= ST_IDLE;
                        end
                        PHASE_COL_HI: begin
                            r_res <= '{tx_valid: 1'b1, tx_is_command: 1'b1,
                                       tx_byte: CMD_COL_HIGH |
                                                (NIBBLE_MASK & (8'(begin_cur) >> 4)),
                                       tx_last: 1'b0};
                            r_phase  <= PHASE_DATA;
                            r_strobe <= 1'b1;
                            r_state  <= ST_IDLE;
                        end
                        default: begin
                            // Data phase: frame read issued this cycle.
                            r_flush_col <= col_use + 1'b1;
                            r_state     <= ST_PULL_DATA;
                        end
                    endcase
                end

                ST_PULL_PAGE: begin
                    r_flush_col <= LEN_W'(begin_cur);
                    r_phase     <= PHASE_COL_LO;
                    r_res <= '{tx_valid: 1'b1, tx_is_command: 1'b1,
                               tx_byte: CMD_PAGE_BASE | {4'h0, 4'(r_page)}, tx_last: 1'b0};
                    r_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end

                ST_PULL_DATA: begin
                    r_res <= '{tx_valid: 1'b1, tx_is_command: 1'b0, tx_byte: ram_rdata,
                               tx_last: flush_done && !others_dirty};
                    if (flush_done) begin
                        // Span sent: page is clean again.
                        r_begin[r_page] <= '0;
                        r_len[r_page]   <= '0;
                        r_phase         <= PHASE_PAGE;
                    end
                    r_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_strobe   = r_strobe;
    assign o_res_word = r_res;

endmodule

### hw/rtl/mprf_ram.sv
// Frame store: one write port, one read port with registered read data.
module mprf_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mprf_checker.sv
// Port-level checker of the page framebuffer and its bind to the top level.
`include "mono_page_rect_fill_flush_defines.svh"

module mprf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                i_strobe,
    input  mprf_pkg::t_res_word i_res_word
);

    logic quiet_ok;

    assign quiet_ok = (i_res_word.tx_byte == 8'h00) && !i_res_word.tx_is_command &&
                      !i_res_word.tx_last;

    // An accepted word either keeps the block busy or is answered in the next cycle.
    `MPRF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy || i_strobe)

    // The result word appears as the block returns to idle.
    `MPRF_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, i_strobe, !busy)

    // No second result word unless a new word was taken in the strobe cycle.
    `MPRF_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, i_strobe && !start, !i_strobe)

    // Words without a flush byte are all zero.
    `MPRF_ASSERT_SAME(a_quiet_zero, i_clk, i_rst_n, i_strobe && !i_res_word.tx_valid, quiet_ok)

endmodule

bind mono_page_rect_fill_flush mprf_checker u_mprf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_strobe   (o_strobe),
    .i_res_word (o_res_word)
);
